>>> hdl/arith_expression_lexer_assert.svh
// Assertion macros shared by the lexer RTL files.
`ifndef ARITH_EXPRESSION_LEXER_ASSERT_SVH
`define ARITH_EXPRESSION_LEXER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define AEL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, also while reset is applied.
`define AEL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ael_pkg.sv
// Shared types, constants and helper functions for the expression lexer.
`timescale 1ns / 1ps
`default_nettype none

package ael_pkg;

	// Width of the internal line, column and length counters
	localparam int POS_BITS = 16;
	localparam int OUT_POS_BITS = 16;

	// Token queue sizing
	localparam int TQ_DEPTH = 4;
	localparam int TQ_PTR_BITS = $clog2(TQ_DEPTH);
	localparam int TQ_CNT_BITS = $clog2(TQ_DEPTH + 1);

	// Source characters with a meaning of their own
	localparam logic [7:0] CH_EOI        = 8'h00;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_VTAB       = 8'h0B;
	localparam logic [7:0] CH_FORMFEED   = 8'h0C;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_DIGIT_LO   = 8'h30;
	localparam logic [7:0] CH_DIGIT_HI   = 8'h39;
	localparam logic [7:0] CH_EQUALS     = 8'h3D;
	localparam logic [7:0] CH_UPPER_LO   = 8'h41;
	localparam logic [7:0] CH_UPPER_HI   = 8'h5A;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_LOWER_LO   = 8'h61;
	localparam logic [7:0] CH_LOWER_HI   = 8'h7A;

	typedef logic [POS_BITS-1:0] pos_t;

	typedef enum logic [3:0] {
		KIND_IDENT   = 4'd0,
		KIND_NUMBER  = 4'd1,
		KIND_PLUS    = 4'd2,
		KIND_MINUS   = 4'd3,
		KIND_STAR    = 4'd4,
		KIND_SLASH   = 4'd5,
		KIND_LPAREN  = 4'd6,
		KIND_RPAREN  = 4'd7,
		KIND_EQUALS  = 4'd8,
		KIND_NEWLINE = 4'd9,
		KIND_UNKNOWN = 4'd10
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t                kind;
		logic                     eof;
		logic [OUT_POS_BITS-1:0]  line;
		logic [OUT_POS_BITS-1:0]  col;
		logic [OUT_POS_BITS-1:0]  len;
		logic [7:0]               ch;
		logic                     last;
	} token_t;

	// Up to two tokens from one source byte, in emission order a then b
	typedef struct packed {
		logic   a_vld;
		token_t a;
		logic   b_vld;
		token_t b;
	} push_t;

	function automatic pos_t sat_inc(input pos_t v);
		return (v == {POS_BITS{1'b1}}) ? v : v + pos_t'(1);
	endfunction

	// Low 16 bits of a counter, zero extended if the counter is narrower
	function automatic logic [OUT_POS_BITS-1:0] pos_out(input pos_t v);
		logic [31:0] w;
		w = 32'(v);
		return w[OUT_POS_BITS-1:0];
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CH_LOWER_LO && c <= CH_LOWER_HI) ||
			(c >= CH_UPPER_LO && c <= CH_UPPER_HI);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_DIGIT_LO && c <= CH_DIGIT_HI;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_VTAB ||
			c == CH_FORMFEED || c == CH_CR;
	endfunction

	function automatic tok_kind_t single_kind(input logic [7:0] c);
		tok_kind_t k;
		unique case (c)
			CH_PLUS:    k = KIND_PLUS;
			CH_MINUS:   k = KIND_MINUS;
			CH_STAR:    k = KIND_STAR;
			CH_SLASH:   k = KIND_SLASH;
			CH_LPAREN:  k = KIND_LPAREN;
			CH_RPAREN:  k = KIND_RPAREN;
			CH_EQUALS:  k = KIND_EQUALS;
			CH_NEWLINE: k = KIND_NEWLINE;
			default:    k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

>>> hdl/ael_scan.sv
// Scanner state and byte classification: turns one source byte into up to two tokens.
`timescale 1ns / 1ps
`default_nettype none

`include "arith_expression_lexer_assert.svh"

module ael_scan (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     char_code,
	input  logic           end_of_input,
	output ael_pkg::push_t push
);
	import ael_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_NUMBER = 2'd2
	} mode_t;

	mode_t mode_q, mode_d;
	pos_t  line_q, line_d;
	pos_t  col_q, col_d;
	pos_t  pst_q, pst_d;
	pos_t  plen_q, plen_d;

	logic   eoi;
	logic   has_pend;
	logic   cont;
	logic   let_c, dig_c;
	push_t  push_d;

	always_comb begin
		eoi      = end_of_input || char_code == CH_EOI;
		let_c    = is_letter(char_code);
		dig_c    = is_digit(char_code);
		has_pend = mode_q != MODE_IDLE;
		cont     = (mode_q == MODE_IDENT && (let_c || dig_c || char_code == CH_UNDERSCORE)) ||
			(mode_q == MODE_NUMBER && dig_c);

		mode_d = mode_q;
		line_d = line_q;
		col_d  = col_q;
		pst_d  = pst_q;
		plen_d = plen_q;

		// slot a: pending identifier or number being flushed
		push_d.a_vld  = 1'b0;
		push_d.a.kind = (mode_q == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
		push_d.a.eof  = 1'b0;
		push_d.a.line = pos_out(line_q);
		push_d.a.col  = pos_out(pst_q);
		push_d.a.len  = pos_out(plen_q);
		push_d.a.ch   = 8'h00;
		push_d.a.last = 1'b0;

		// slot b: single-char token or eof at the current position
		push_d.b_vld  = 1'b0;
		push_d.b.kind = single_kind(char_code);
		push_d.b.eof  = 1'b0;
		push_d.b.line = pos_out(line_q);
		push_d.b.col  = pos_out(col_q);
		push_d.b.len  = OUT_POS_BITS'(1);
		push_d.b.ch   = char_code;
		push_d.b.last = 1'b1;

		if (eoi) begin
			push_d.a_vld  = has_pend;
			push_d.b_vld  = 1'b1;
			push_d.b.kind = KIND_IDENT;
			push_d.b.eof  = 1'b1;
			push_d.b.len  = '0;
			push_d.b.ch   = 8'h00;
			mode_d = MODE_IDLE;
			line_d = pos_t'(1);
			col_d  = pos_t'(1);
			pst_d  = '0;
			plen_d = '0;
		end else if (cont) begin
			plen_d = sat_inc(plen_q);
			col_d  = sat_inc(col_q);
		end else begin
			push_d.a_vld = has_pend;
			mode_d = MODE_IDLE;
			pst_d  = '0;
			plen_d = '0;
			if (let_c || dig_c) begin
				mode_d = let_c ? MODE_IDENT : MODE_NUMBER;
				pst_d  = col_q;
				plen_d = pos_t'(1);
				col_d  = sat_inc(col_q);
			end else if (is_blank(char_code)) begin
				col_d = sat_inc(col_q);
			end else begin
				push_d.b_vld = 1'b1;
				if (char_code == CH_NEWLINE) begin
					line_d = sat_inc(line_q);
					col_d  = pos_t'(1);
				end else begin
					col_d = sat_inc(col_q);
				end
			end
		end

		push_d.a.last = !push_d.b_vld;

		push       = push_d;
		push.a_vld = push_d.a_vld && step;
		push.b_vld = push_d.b_vld && step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= pos_t'(1);
			col_q  <= pos_t'(1);
			pst_q  <= '0;
			plen_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q  <= col_d;
			pst_q  <= pst_d;
			plen_q <= plen_d;
		end
	end

	`AEL_ASSERT(a_eoi_resets, step && eoi |=> mode_q == MODE_IDLE && line_q == pos_t'(1) && col_q == pos_t'(1), "end of input did not return scanner to reset state")

endmodule

`default_nettype wire

>>> hdl/ael_tok_fifo.sv
// Small token queue: takes up to two tokens per cycle, hands out one per cycle while tok_stall is low.
`timescale 1ns / 1ps
`default_nettype none

`include "arith_expression_lexer_assert.svh"

module ael_tok_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  ael_pkg::push_t  push,
	output logic            room,
	output logic            tok_valid,
	input  logic            tok_stall,
	output ael_pkg::token_t head
);
	import ael_pkg::*;

	token_t                 mem_q [TQ_DEPTH];
	logic [TQ_PTR_BITS-1:0] wr_q, rd_q;
	logic [TQ_CNT_BITS-1:0] cnt_q;
	logic [1:0]             n_push;
	logic                   pop;
	token_t                 first;

	always_comb begin
		n_push    = {1'b0, push.a_vld} + {1'b0, push.b_vld};
		first     = push.a_vld ? push.a : push.b;
		tok_valid = cnt_q != '0;
		pop       = tok_valid && !tok_stall;
		head      = mem_q[rd_q];
		// space for a worst-case pair
		room      = cnt_q <= TQ_CNT_BITS'(TQ_DEPTH - 2);
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_q] <= first;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_q + TQ_PTR_BITS'(1)] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + TQ_PTR_BITS'(n_push);
			rd_q  <= rd_q + TQ_PTR_BITS'(pop);
			cnt_q <= cnt_q + TQ_CNT_BITS'(n_push) - TQ_CNT_BITS'(pop);
		end
	end

	`AEL_ASSERT(a_push_has_room, (push.a_vld || push.b_vld) |-> room, "token push without room")
	`AEL_ASSERT(a_cnt_bound, cnt_q <= TQ_CNT_BITS'(TQ_DEPTH), "token queue count out of range")

endmodule

`default_nettype wire

>>> hdl/arith_expression_lexer.sv
// Top level of the streaming arithmetic expression lexer.
`timescale 1ns / 1ps
`default_nettype none

`include "arith_expression_lexer_assert.svh"

// Streaming lexer for simple arithmetic expressions. One source byte is
// accepted per cycle on the src channel; finished tokens leave on the tok
// channel with kind, start line, start column and length (token text is not
// carried). Identifiers (letter, then letters, digits, underscores) and
// numbers (digit runs) accumulate silently; + - * / ( ) = and newline give
// one token each, blanks are skipped, anything else is an unknown token.
// Byte 0 or end_of_input flushes the pending token, sends an end-of-file
// token and returns the lexer to its reset state. last_of_run marks the
// final token produced by a byte. Line, column and length saturate.
// Throughput: one byte per cycle while src_stall is low. A byte gives zero,
// one or two tokens and the tok channel drains one token per cycle while
// tok_stall is low. Two tokens come only from a byte that ends a pending
// word, and the bytes inside that word gave none, so with tok_stall low the
// lexer keeps taking a byte every cycle; the queue soaks up the extra token
// of a pair. Each byte is held in the input register, then its tokens are
// written into the four-entry token queue, which drives tok_valid. src_stall
// comes from registers only: it rises while the queue holds more than two
// tokens and a byte is waiting.

module arith_expression_lexer (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,

	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [3:0]  token_kind,
	output logic        is_eof,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic [15:0] token_length,
	output logic [7:0]  single_char,
	output logic        last_of_run
);
	import ael_pkg::*;

	// input word register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;

	logic   room;
	logic   step;
	logic   src_take;
	push_t  push;
	token_t head;

	// byte in the input register is scanned once the queue can take a pair
	assign step      = valid_s1 && room;
	assign src_stall = valid_s1 && !room;
	assign src_take  = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_take) begin
			char_s1 <= char_code;
			eoi_s1  <= end_of_input;
		end
	end

	ael_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.char_code    (char_s1),
		.end_of_input (eoi_s1),
		.push         (push)
	);

	ael_tok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.head      (head)
	);

	assign token_kind   = 4'(head.kind);
	assign is_eof       = head.eof;
	assign start_line   = head.line;
	assign start_column = head.col;
	assign token_length = head.len;
	assign single_char  = head.ch;
	assign last_of_run  = head.last;

	`AEL_ASSERT(a_eof_is_last, tok_valid && is_eof |-> last_of_run, "eof word not last of its run")
	`AEL_ASSERT(a_eof_shape, tok_valid && is_eof |-> token_kind == KIND_IDENT, "eof word with a kind")
	`AEL_ASSERT(a_eof_empty, tok_valid && is_eof |-> token_length == 16'd0 && single_char == 8'h00, "eof word not empty")

endmodule

`default_nettype wire

>>> tb/tb_arith_expression_lexer.sv
// Self-checking testbench for the streaming arithmetic expression lexer.
`timescale 1ns / 1ps

module tb_arith_expression_lexer;
	import ael_pkg::*;

	// Run limits. The slowest correct run (about 1100 words, each waiting out its
	// idle gap and giving up to two tokens, each held by a random receiver stall,
	// plus two long holds) still leaves plenty of margin under the limit.
	localparam int CYCLE_LIMIT  = 500_000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 250;
	localparam int RANDOM_WORDS = 1050;

	// Lexer scan state, as the predictor tracks it
	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_WORD,
		SCAN_NUM
	} scan_t;

	// One source word waiting in the stimulus queue, with its idle gap
	typedef struct packed {
		logic [7:0] code;
		logic       eoi;
		logic [3:0] gap;
	} src_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        src_valid = 1'b0;
	logic        src_stall;
	logic [7:0]  char_code = 8'h00;
	logic        end_of_input = 1'b0;

	logic        tok_valid;
	logic        tok_stall;
	logic [3:0]  token_kind;
	logic        is_eof;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic [15:0] token_length;
	logic [7:0]  single_char;
	logic        last_of_run;

	arith_expression_lexer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.is_eof       (is_eof),
		.start_line   (start_line),
		.start_column (start_column),
		.token_length (token_length),
		.single_char  (single_char),
		.last_of_run  (last_of_run)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Token predictor: its own copy of the lexer state, starting at reset
	// ------------------------------------------------------------------
	scan_t       scan_state = SCAN_IDLE;
	logic [15:0] line_no    = 16'd1;
	logic [15:0] col_no     = 16'd1;
	logic [15:0] tok_start  = 16'd0;
	logic [15:0] tok_len    = 16'd0;

	token_t      expected_tokens[$];
	int          failures = 0;

	// Line, column and length stick at all ones
	function automatic logic [15:0] sat_up(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic void push_token(input tok_kind_t k, input logic eof,
			input logic [15:0] ln, input logic [15:0] cl, input logic [15:0] len,
			input logic [7:0] ch, input logic last);
		token_t t;
		t.kind = k;
		t.eof  = eof;
		t.line = ln;
		t.col  = cl;
		t.len  = len;
		t.ch   = ch;
		t.last = last;
		expected_tokens = {expected_tokens, t};
	endfunction

	// Emit the identifier or number in progress, if any, and go idle
	function automatic void flush_word(input logic last);
		if (scan_state == SCAN_WORD)
			push_token(KIND_IDENT, 1'b0, line_no, tok_start, tok_len, 8'h00, last);
		else if (scan_state == SCAN_NUM)
			push_token(KIND_NUMBER, 1'b0, line_no, tok_start, tok_len, 8'h00, last);
		scan_state = SCAN_IDLE;
		tok_start  = 16'd0;
		tok_len    = 16'd0;
	endfunction

	// Expected tokens for one accepted source word
	function automatic void lex_byte(input logic [7:0] c, input logic eoi_flag);
		logic      alpha;
		logic      num;
		logic      blank;
		logic      emits_single;
		tok_kind_t k;
		alpha = c inside {[CH_UPPER_LO:CH_UPPER_HI], [CH_LOWER_LO:CH_LOWER_HI]};
		num   = c inside {[CH_DIGIT_LO:CH_DIGIT_HI]};
		blank = c inside {CH_SPACE, CH_TAB, CH_VTAB, CH_FORMFEED, CH_CR};
		emits_single = !(alpha || num || blank);
		if (eoi_flag || c == CH_EOI) begin
			// pending word first, then end-of-file (its kind field reads zero)
			flush_word(1'b0);
			push_token(KIND_IDENT, 1'b1, line_no, col_no, 16'd0, 8'h00, 1'b1);
			line_no = 16'd1;
			col_no  = 16'd1;
		end else if ((scan_state == SCAN_WORD && (alpha || num || c == CH_UNDERSCORE)) ||
				(scan_state == SCAN_NUM && num)) begin
			tok_len = sat_up(tok_len);
			col_no  = sat_up(col_no);
		end else begin
			flush_word(!emits_single);
			if (alpha || num) begin
				scan_state = alpha ? SCAN_WORD : SCAN_NUM;
				tok_start  = col_no;
				tok_len    = 16'd1;
				col_no     = sat_up(col_no);
			end else if (blank) begin
				col_no = sat_up(col_no);
			end else begin
				case (c)
					CH_PLUS:    k = KIND_PLUS;
					CH_MINUS:   k = KIND_MINUS;
					CH_STAR:    k = KIND_STAR;
					CH_SLASH:   k = KIND_SLASH;
					CH_LPAREN:  k = KIND_LPAREN;
					CH_RPAREN:  k = KIND_RPAREN;
					CH_EQUALS:  k = KIND_EQUALS;
					CH_NEWLINE: k = KIND_NEWLINE;
					default:    k = KIND_UNKNOWN;
				endcase
				push_token(k, 1'b0, line_no, col_no, 16'd1, c, 1'b1);
				if (c == CH_NEWLINE) begin
					line_no = sat_up(line_no);
					col_no  = 16'd1;
				end else begin
					col_no = sat_up(col_no);
				end
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Source driver: pops words from source_bytes, waits each word's gap,
	// then holds the word on the bus until the lexer takes it.
	// ------------------------------------------------------------------
	src_word_t   source_bytes[$];
	src_word_t   staged_word;
	logic        staged = 1'b0;
	logic [3:0]  gap_left = 4'd0;

	always @(posedge clk or negedge arst_n) begin
		src_word_t w;
		if (!arst_n) begin
			src_valid    <= 1'b0;
			char_code    <= 8'h00;
			end_of_input <= 1'b0;
			staged       <= 1'b0;
			gap_left     <= 4'd0;
		end else begin
			if (src_valid && !src_stall)
				lex_byte(char_code, end_of_input);
			// a stalled word stays put; otherwise move on to the next one
			if (!src_valid || !src_stall) begin
				if (staged) begin
					if (gap_left == 4'd0) begin
						src_valid    <= 1'b1;
						char_code    <= staged_word.code;
						end_of_input <= staged_word.eoi;
						staged       <= 1'b0;
					end else begin
						src_valid <= 1'b0;
						gap_left  <= gap_left - 4'd1;
					end
				end else if (source_bytes.size() != 0) begin
					w = source_bytes.pop_front();
					if (w.gap == 4'd0) begin
						src_valid    <= 1'b1;
						char_code    <= w.code;
						end_of_input <= w.eoi;
					end else begin
						src_valid   <= 1'b0;
						staged      <= 1'b1;
						staged_word <= w;
						gap_left    <= w.gap - 4'd1;
					end
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Token monitor: checks each accepted word against the oldest
	// expectation and draws its own stall before the next one.
	// ------------------------------------------------------------------
	logic        rx_stall = 1'b0;
	logic [3:0]  rx_wait = 4'd0;
	logic        rx_quiet = 1'b0;
	int          tokens_seen = 0;
	int          hold_left = 0;
	int          holds_done = 0;

	assign tok_stall = rx_stall | (hold_left != 0);

	always @(posedge clk or negedge arst_n) begin
		token_t     want;
		token_t     got;
		logic       bad;
		logic [3:0] w;
		if (!arst_n) begin
			rx_stall    <= 1'b0;
			rx_wait     <= 4'd0;
			rx_quiet    <= 1'b0;
			tokens_seen <= 0;
		end else if (tok_valid && !tok_stall) begin
			got.kind = tok_kind_t'(token_kind);
			got.eof  = is_eof;
			got.line = start_line;
			got.col  = start_column;
			got.len  = token_length;
			got.ch   = single_char;
			got.last = last_of_run;
			if (expected_tokens.size() == 0) begin
				if (failures < 10)
					$display("[%0t] unexpected word: kind=%0d eof=%0b line=%0d col=%0d",
						$realtime, got.kind, got.eof, got.line, got.col,
						" len=%0d ch=%02h last=%0b", got.len, got.ch, got.last);
				failures = failures + 1;
			end else begin
				want = expected_tokens.pop_front();
				bad = (got.kind !== want.kind) || (got.eof !== want.eof) ||
					(got.line !== want.line) || (got.col !== want.col) ||
					(got.len !== want.len) || (got.ch !== want.ch) ||
					(got.last !== want.last);
				if (bad) begin
					if (failures < 10)
						$display("[%0t] mismatch: exp kind=%0d eof=%0b line=%0d col=%0d",
							$realtime, want.kind, want.eof, want.line, want.col,
							" len=%0d ch=%02h last=%0b", want.len, want.ch, want.last,
							" | got kind=%0d eof=%0b line=%0d col=%0d",
							got.kind, got.eof, got.line, got.col,
							" len=%0d ch=%02h last=%0b", got.len, got.ch, got.last);
					failures = failures + 1;
				end
			end
			tokens_seen <= tokens_seen + 1;
			// every 64 words, maybe switch to a stretch with no stalls
			if (tokens_seen % 64 == 0)
				rx_quiet <= ($urandom_range(0, 3) == 0);
			w = rx_quiet ? 4'd0 : 4'($urandom_range(0, 15));
			rx_wait  <= w;
			rx_stall <= (w != 4'd0);
		end else if (rx_wait != 4'd0) begin
			rx_wait  <= rx_wait - 4'd1;
			rx_stall <= (rx_wait != 4'd1);
		end
	end

	// Long receiver hold-offs, twice, so the token queue fills and the lexer
	// has to stall its source side while the driver keeps offering words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && tokens_seen >= 200 + holds_done * 450) begin
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// Watchdog
	int cycle_count = 0;

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("arith_expression_lexer regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	int         gap_limit = 15;
	int         words_queued = 0;
	logic [7:0] op_chars[8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
		CH_LPAREN, CH_RPAREN, CH_EQUALS, CH_NEWLINE};
	logic [7:0] blank_chars[5] = '{CH_SPACE, CH_TAB, CH_VTAB, CH_FORMFEED, CH_CR};

	function automatic void add_byte(input logic [7:0] c, input logic eoi);
		src_word_t w;
		w.code = c;
		w.eoi  = eoi;
		w.gap  = 4'($urandom_range(0, gap_limit));
		source_bytes = {source_bytes, w};
		words_queued = words_queued + 1;
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], 1'b0);
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1) == 0)
			return CH_LOWER_LO + 8'($urandom_range(0, 25));
		return CH_UPPER_LO + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_DIGIT_LO + 8'($urandom_range(0, 9));
	endfunction

	// One random source text: mostly well-formed expression pieces, some
	// noise, always closed by an end of input in one of its two forms.
	function automatic void add_program();
		int pieces;
		int len;
		pieces = $urandom_range(3, 30);
		gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 15;
		for (int p = 0; p < pieces; p++) begin
			case ($urandom_range(0, 11))
				0, 1, 2: begin
					add_byte(rand_letter(), 1'b0);
					len = $urandom_range(0, 7);
					for (int i = 0; i < len; i++)
						case ($urandom_range(0, 3))
							0:       add_byte(rand_digit(), 1'b0);
							1:       add_byte(CH_UNDERSCORE, 1'b0);
							default: add_byte(rand_letter(), 1'b0);
						endcase
				end
				3, 4: begin
					len = $urandom_range(1, 6);
					for (int i = 0; i < len; i++)
						add_byte(rand_digit(), 1'b0);
				end
				5, 6, 7: add_byte(op_chars[$urandom_range(0, 7)], 1'b0);
				8, 9:    add_byte(blank_chars[$urandom_range(0, 4)], 1'b0);
				10:      add_byte(CH_UNDERSCORE, 1'b0);
				default: add_byte(8'($urandom_range(1, 255)), 1'b0);
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			add_byte(CH_EOI, 1'b0);
		else
			add_byte(8'($urandom_range(0, 255)), 1'b1);
	endfunction

	// Block until every queued word went in and every token came out
	task automatic wait_idle();
		while (source_bytes.size() != 0 || staged || src_valid ||
				expected_tokens.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: letter and digit extremes, underscore inside and first,
		// every operator but plus, equals, newline, all blanks, high bytes, trailing
		// blanks before end of input, a word ended by terminating bytes, and
		// both forms of end of input, the zero byte one with a word pending.
		add_text("Az9_ 0189/(_)");
		add_byte(CH_TAB, 1'b0);
		add_text("=*");
		add_byte(CH_NEWLINE, 1'b0);
		add_text("-");
		add_byte(8'hFF, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(CH_VTAB, 1'b0);
		add_byte(CH_FORMFEED, 1'b0);
		add_byte(CH_CR, 1'b0);
		add_byte(CH_SPACE, 1'b0);
		add_byte(8'hA5, 1'b1);
		add_text("z7");
		add_byte(CH_EOI, 1'b0);
		wait_idle();

		// Random texts
		words_queued = 0;
		while (words_queued < RANDOM_WORDS)
			add_program();
		wait_idle();

		// let any stray token show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("arith_expression_lexer regression: pass");
		else
			$display("arith_expression_lexer regression: fail");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/ael_pkg.sv
hdl/ael_scan.sv
hdl/ael_tok_fifo.sv
hdl/arith_expression_lexer.sv
tb/tb_arith_expression_lexer.sv
